>>> rtl/core/dirty_range_coalescer_assert.svh
// -----------------------------------------------------------------------------
// Assertion macros for the dirty range coalescer
// Shared clocked property wrappers, reset masked.
// -----------------------------------------------------------------------------
`ifndef DIRTY_RANGE_COALESCER_ASSERT_SVH
`define DIRTY_RANGE_COALESCER_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define DRC_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle
`define DRC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/drc_pkg.sv
// -----------------------------------------------------------------------------
// drc_pkg
// Types, widths and codes shared by the dirty range coalescer.
// -----------------------------------------------------------------------------
package drc_pkg;

   localparam int ENTRIES_DEF = 1024;
   localparam int CMD_W       = 2;
   localparam int DATA_W      = 32;
   localparam int INDEX_W     = 10;
   localparam int STATUS_W    = 2;
   localparam int COUNT_W     = 10;
   localparam int LOG_W       = 5;

   localparam logic [LOG_W-1:0] BLOCK_LOG_RESET = 5'd12;

   // command codes
   localparam logic [CMD_W-1:0] CMD_MARK  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

   // status codes
   localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_RANGE = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ALIGN,
      ST_SIZE,
      ST_SCAN,
      ST_READ,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [COUNT_W-1:0]  entry_count;
      logic [DATA_W-1:0]   entry_start;
      logic [DATA_W-1:0]   entry_length;
   } result_type;

   // engine to output stage
   typedef struct packed {
      logic       valid;
      result_type data;
   } handoff_type;

endpackage

>>> rtl/core/drc_if.sv
// -----------------------------------------------------------------------------
// drc channel interfaces
// Request, response and register write channels, valid/ready handshake.
// -----------------------------------------------------------------------------
interface drc_req_if;
   logic                           valid;
   logic                           ready;
   logic [drc_pkg::CMD_W-1:0]      cmd;
   logic [drc_pkg::DATA_W-1:0]     range_offset;
   logic [drc_pkg::DATA_W-1:0]     range_length;
   logic [drc_pkg::INDEX_W-1:0]    entry_index;

   modport source (output valid, cmd, range_offset, range_length, entry_index, input ready);
   modport sink   (input valid, cmd, range_offset, range_length, entry_index, output ready);
endinterface

interface drc_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [drc_pkg::STATUS_W-1:0]   status;
   logic [drc_pkg::COUNT_W-1:0]    entry_count;
   logic [drc_pkg::DATA_W-1:0]     entry_start;
   logic [drc_pkg::DATA_W-1:0]     entry_length;

   modport source (output valid, status, entry_count, entry_start, entry_length, input ready);
   modport sink   (input valid, status, entry_count, entry_start, entry_length, output ready);
endinterface

interface drc_csr_if;
   logic                           valid;
   logic                           ready;
   logic [drc_pkg::LOG_W-1:0]      block_log;

   modport source (output valid, block_log, input ready);
   modport sink   (input valid, block_log, output ready);
endinterface

>>> rtl/core/drc_ram.sv
// -----------------------------------------------------------------------------
// drc_ram
// Generic single write port, single read port RAM with registered read.
// -----------------------------------------------------------------------------
module drc_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = drc_pkg::ENTRIES_DEF
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/drc_engine.sv
// -----------------------------------------------------------------------------
// drc_engine
// Command sequencer: aligns mark ranges, scans the entry RAM and merges or appends; also serves read and clear.
// -----------------------------------------------------------------------------
`include "dirty_range_coalescer_assert.svh"

module drc_engine #(
   parameter int ENTRIES = drc_pkg::ENTRIES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [drc_pkg::LOG_W-1:0]     block_log,
   drc_req_if.sink                       req_ch,
   output drc_pkg::handoff_type          handoff,
   input  logic                          handoff_take
);

   localparam int ADDR_W = $clog2(ENTRIES);
   localparam int DW     = drc_pkg::DATA_W;
   localparam logic [ADDR_W-1:0] LAST_CNT = ADDR_W'(ENTRIES - 1);

   drc_pkg::state_type state_ff, state_in;

   logic [ADDR_W-1:0]               count_ff, count_in;
   logic [ADDR_W-1:0]               eval_idx_ff, eval_idx_in;
   logic [DW-1:0]                   off_ff, off_in;
   logic [DW-1:0]                   end_ff, end_in;
   logic [DW-1:0]                   ns_ff, ns_in;
   logic [DW-1:0]                   ne_ff, ne_in;
   logic [DW-1:0]                   nl_ff, nl_in;
   logic [drc_pkg::STATUS_W-1:0]    res_status_ff, res_status_in;
   logic [DW-1:0]                   res_start_ff, res_start_in;
   logic [DW-1:0]                   res_length_ff, res_length_in;

   logic                            wr_en, rd_en;
   logic [ADDR_W-1:0]               wr_addr, rd_addr;
   logic [2*DW-1:0]                 wr_data, rd_data;

   logic [DW-1:0]                   mask, bsize, nl_calc;
   logic [DW-1:0]                   es, el, ee;
   logic                            hit;
   logic [DW-1:0]                   new_start, new_length;

   // entry store: start in the upper half, length in the lower half
   drc_ram #(
      .WIDTH (2 * DW),
      .DEPTH (ENTRIES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign mask     = ~({DW{1'b1}} << block_log);
   assign bsize    = mask + DW'(1);
   assign nl_calc  = ne_ff - ns_ff;

   // merge test of the stored entry against the aligned range
   always_comb begin
      es         = rd_data[2*DW-1:DW];
      el         = rd_data[DW-1:0];
      ee         = es + el;
      hit        = 1'b0;
      new_start  = es;
      new_length = el;
      if (ns_ff > es) begin
         hit = (ee >= ns_ff);
         if (ee < ne_ff) begin
            new_length = ne_ff - es;
         end
      end else if (es > ns_ff) begin
         hit       = (ne_ff >= es);
         new_start = ns_ff;
         if (ne_ff < ee) begin
            new_length = ee - ns_ff;
         end else begin
            new_length = nl_ff;
         end
      end else begin
         hit = 1'b1;
         if (nl_ff > el) begin
            new_length = nl_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= drc_pkg::ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      eval_idx_ff   <= eval_idx_in;
      off_ff        <= off_in;
      end_ff        <= end_in;
      ns_ff         <= ns_in;
      ne_ff         <= ne_in;
      nl_ff         <= nl_in;
      res_status_ff <= res_status_in;
      res_start_ff  <= res_start_in;
      res_length_ff <= res_length_in;
   end

   // next state and datapath control
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      eval_idx_in   = eval_idx_ff;
      off_in        = off_ff;
      end_in        = end_ff;
      ns_in         = ns_ff;
      ne_in         = ne_ff;
      nl_in         = nl_ff;
      res_status_in = res_status_ff;
      res_start_in  = res_start_ff;
      res_length_in = res_length_ff;
      wr_en         = 1'b0;
      wr_addr       = count_ff;
      wr_data       = {ns_ff, nl_calc};
      rd_en         = 1'b0;
      rd_addr       = ADDR_W'(req_ch.entry_index);
      req_ch.ready  = 1'b0;
      handoff.valid = 1'b0;
      handoff.data  = '{status:       res_status_ff,
                        entry_count:  drc_pkg::COUNT_W'(32'(count_ff)),
                        entry_start:  res_start_ff,
                        entry_length: res_length_ff};

      case (state_ff)
         // ready is high here, so valid alone marks an accepted item
         drc_pkg::ST_IDLE: begin
            req_ch.ready = 1'b1;
            if (req_ch.valid) begin
               res_status_in = drc_pkg::STAT_OK;
               res_start_in  = '0;
               res_length_in = '0;
               state_in      = drc_pkg::ST_RESP;
               case (req_ch.cmd)
                  drc_pkg::CMD_MARK: begin
                     off_in   = req_ch.range_offset;
                     end_in   = req_ch.range_offset + req_ch.range_length;
                     state_in = drc_pkg::ST_ALIGN;
                  end
                  drc_pkg::CMD_READ: begin
                     if (32'(req_ch.entry_index) < 32'(count_ff)) begin
                        rd_en    = 1'b1;
                        state_in = drc_pkg::ST_READ;
                     end else begin
                        res_status_in = drc_pkg::STAT_RANGE;
                     end
                  end
                  drc_pkg::CMD_CLEAR: begin
                     count_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end

         // round start down and end up to the block size
         drc_pkg::ST_ALIGN: begin
            ns_in = off_ff & ~mask;
            if ((end_ff & mask) != '0) begin
               ne_in = (end_ff & ~mask) + bsize;
            end else begin
               ne_in = end_ff;
            end
            state_in = drc_pkg::ST_SIZE;
         end

         // length of the aligned range; start the scan or append at once
         drc_pkg::ST_SIZE: begin
            nl_in = nl_calc;
            if (count_ff == '0) begin
               wr_en    = 1'b1;
               count_in = count_ff + ADDR_W'(1);
               state_in = drc_pkg::ST_RESP;
            end else begin
               rd_en       = 1'b1;
               rd_addr     = '0;
               eval_idx_in = '0;
               state_in    = drc_pkg::ST_SCAN;
            end
         end

         // one entry per cycle, read of the next entry overlaps the test
         drc_pkg::ST_SCAN: begin
            if (hit) begin
               wr_en    = 1'b1;
               wr_addr  = eval_idx_ff;
               wr_data  = {new_start, new_length};
               state_in = drc_pkg::ST_RESP;
            end else if (eval_idx_ff + ADDR_W'(1) == count_ff) begin
               state_in = drc_pkg::ST_RESP;
               if (count_ff == LAST_CNT) begin
                  res_status_in = drc_pkg::STAT_FULL;
               end else begin
                  wr_en    = 1'b1;
                  wr_data  = {ns_ff, nl_ff};
                  count_in = count_ff + ADDR_W'(1);
               end
            end else begin
               rd_en       = 1'b1;
               rd_addr     = eval_idx_ff + ADDR_W'(1);
               eval_idx_in = eval_idx_ff + ADDR_W'(1);
            end
         end

         drc_pkg::ST_READ: begin
            res_start_in  = rd_data[2*DW-1:DW];
            res_length_in = rd_data[DW-1:0];
            state_in      = drc_pkg::ST_RESP;
         end

         drc_pkg::ST_RESP: begin
            handoff.valid = 1'b1;
            if (handoff_take) begin
               state_in = drc_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = drc_pkg::ST_IDLE;
         end
      endcase
   end

   // checks
   `DRC_ASSERT_SAME(a_scan_in_range, clock, reset, state_ff == drc_pkg::ST_SCAN, eval_idx_ff < count_ff, "scan index past entry count")
   `DRC_ASSERT_SAME(a_write_when_marking, clock, reset, wr_en, state_ff == drc_pkg::ST_SCAN || state_ff == drc_pkg::ST_SIZE, "entry write outside a mark")
   `DRC_ASSERT_NEXT(a_append_counts, clock, reset, wr_en && wr_addr == count_ff && state_ff == drc_pkg::ST_SIZE, count_ff == $past(count_ff) + ADDR_W'(1), "append did not bump count")
   `DRC_ASSERT_SAME(a_count_bound, clock, reset, 1'b1, count_ff <= LAST_CNT, "entry count above table limit")

endmodule

>>> rtl/core/drc_out_stage.sv
// -----------------------------------------------------------------------------
// drc_out_stage
// Result register between the engine and the response channel.
// -----------------------------------------------------------------------------
module drc_out_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  drc_pkg::handoff_type  handoff,
   output logic                  handoff_take,
   drc_rsp_if.source             rsp_ch
);

   logic                 valid_ff, valid_in;
   drc_pkg::result_type  data_ff, data_in;

   assign handoff_take = handoff.valid && (!valid_ff || rsp_ch.ready);

   // hold a result until the sink takes it
   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (handoff_take) begin
         valid_in = 1'b1;
         data_in  = handoff.data;
      end else if (rsp_ch.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_ch.valid        = valid_ff;
   assign rsp_ch.status       = data_ff.status;
   assign rsp_ch.entry_count  = data_ff.entry_count;
   assign rsp_ch.entry_start  = data_ff.entry_start;
   assign rsp_ch.entry_length = data_ff.entry_length;

endmodule

>>> rtl/core/dirty_range_coalescer.sv
// -----------------------------------------------------------------------------
// dirty_range_coalescer
// Dirty range table with block alignment and merge of touching ranges.
// -----------------------------------------------------------------------------
// One item is taken at a time. A mark passes from acceptance to a ready result
// through align, size, a scan step per stored entry tested, and hand-off; the
// scan runs at one entry per cycle, set by the single read port of the entry
// RAM. A read passes through a RAM read step before the hand-off, unless its
// index is not below the count; a clear or unused command goes straight to the
// hand-off. The next item can be accepted in the cycle after the result moves
// into the result register. The result register lets the next item be accepted
// while a result waits. The entry RAM is not cleared; only entries below the
// count are ever read.
// -----------------------------------------------------------------------------
module dirty_range_coalescer #(
   parameter int ENTRIES = drc_pkg::ENTRIES_DEF
) (
   input  logic       clock,
   input  logic       reset,
   drc_csr_if.sink    csr_ch,
   drc_req_if.sink    req_ch,
   drc_rsp_if.source  rsp_ch
);

   logic [drc_pkg::LOG_W-1:0] block_log_ff, block_log_in;
   drc_pkg::handoff_type      handoff;
   logic                      handoff_take;

   // block size register, always writable
   assign csr_ch.ready = 1'b1;

   always_comb begin
      block_log_in = block_log_ff;
      if (csr_ch.valid && csr_ch.ready) begin
         block_log_in = csr_ch.block_log;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         block_log_ff <= drc_pkg::BLOCK_LOG_RESET;
      end else begin
         block_log_ff <= block_log_in;
      end
   end

   drc_engine #(
      .ENTRIES (ENTRIES)
   ) u_engine (
      .clock        (clock),
      .reset        (reset),
      .block_log    (block_log_ff),
      .req_ch       (req_ch),
      .handoff      (handoff),
      .handoff_take (handoff_take)
   );

   drc_out_stage u_out (
      .clock        (clock),
      .reset        (reset),
      .handoff      (handoff),
      .handoff_take (handoff_take),
      .rsp_ch       (rsp_ch)
   );

endmodule
